// ----- src/mfqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mfqs_pkg;

  // fixed field widths of the request and response items
  localparam int CMD_W     = 2;
  localparam int TASK_W    = 8;
  localparam int LEVEL_W   = 4;
  localparam int LVL_OUT_W = 3;
  localparam int STATUS_W  = 2;
  // level with one spare bit so that level + 1 never wraps
  localparam int LVLX_W    = LEVEL_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_FINISH   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TASK_W-1:0]  task_id;
    logic [LEVEL_W-1:0] level;
    logic               is_zombie;
  } req_t;

  typedef struct packed {
    logic                 task_valid;
    logic [TASK_W-1:0]    task_out;
    logic [LVL_OUT_W-1:0] level_out;
    status_e              status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/mfqs_slot_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// task id store, one write and one registered read port
module mfqs_slot_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/mfqs_desc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// per-level descriptor store; an entry never written reads as zero
module mfqs_desc_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_word;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_word : '0;

endmodule

`default_nettype wire

// ----- src/multilevel_feedback_queue_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// timing: the result is registered out of S_LOOK, after the descriptor read, for enqueue, finish,
//   no-op and a dispatch with nothing ready; a dispatch that hands out a task goes on through
//   S_FETCH (descriptor read, then task id read); a stalled output parks the result in S_DONE
// one item at a time: the next request is taken once the result reaches the output register
// reset: head, tail and count of every level read as zero at once (descriptor valid bits);
//   the task id store is not cleared and needs no clearing pass
module multilevel_feedback_queue_scheduler #(
  parameter int NUM_LEVELS   = 8,
  parameter int LEVEL_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mfqs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mfqs_pkg::rsp_t rsp
);

  import mfqs_pkg::*;

  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int PW  = $clog2(LEVEL_DEPTH);
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int SN  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW  = $clog2(SN);
  // stored task ids keep only the bits that survive the id mask
  localparam int SW  = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;

  // per-level ring descriptor
  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] count;
  } desc_t;

  localparam int DW = $bits(desc_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FETCH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_t;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // control and pipeline registers
  state_t                state;
  op_t                   op;
  logic [LVLX_W-1:0]     tgt;
  logic [SW-1:0]         tid;
  rsp_t                  res;
  rsp_t                  rsp_q;
  logic                  out_valid;
  // one bit per level: level holds at least one task
  logic [NUM_LEVELS-1:0] nonempty;

  // decode of the incoming item
  op_t               op_n;
  logic [LVLX_W-1:0] tgt_n;
  rsp_t              res_n;
  logic [LW-1:0]     pick;
  logic              accept;

  // descriptor and slot store ports
  logic          desc_re;
  logic          desc_we;
  logic [DW-1:0] desc_rd;
  desc_t         desc_q;
  desc_t         desc_wd;
  logic          slot_we;
  logic          slot_re;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] slot_base;
  logic [SW-1:0] slot_rd;

  // completion of the current item
  logic                  fin;
  rsp_t                  fin_res;
  logic                  out_free;
  logic [NUM_LEVELS-1:0] ne_next;
  logic [LW-1:0]         lvl;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !out_valid || !rsp_stall;
  assign rsp_valid = out_valid;
  assign rsp       = rsp_q;

  // highest priority level with work: lowest index that is not empty
  always_comb begin
    pick = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pick = LW'(i);
      end
    end
  end

  // every decision that needs no stored pointer is taken at the transfer
  always_comb begin
    op_n  = OP_NONE;
    tgt_n = {1'b0, req.level};
    res_n = '0;
    case (req.cmd)
      CMD_ENQUEUE: begin
        if (tgt_n >= LVLX_W'(NUM_LEVELS)) begin
          res_n.status = ST_RANGE;
        end else begin
          op_n            = OP_PUSH;
          res_n.level_out = tgt_n[LVL_OUT_W-1:0];
        end
      end
      CMD_DISPATCH: begin
        if (nonempty == '0) begin
          res_n.status = ST_EMPTY;
        end else begin
          op_n            = OP_POP;
          tgt_n           = LVLX_W'(pick);
          res_n.level_out = tgt_n[LVL_OUT_W-1:0];
        end
      end
      CMD_FINISH: begin
        // a dead task is simply dropped; a live one sinks one level, but stays on the last level
        if (!req.is_zombie) begin
          if ({1'b0, req.level} + 1'b1 < LVLX_W'(NUM_LEVELS)) begin
            tgt_n = {1'b0, req.level} + 1'b1;
          end
          if (tgt_n >= LVLX_W'(NUM_LEVELS)) begin
            res_n.status = ST_RANGE;
          end else begin
            op_n            = OP_PUSH;
            res_n.level_out = tgt_n[LVL_OUT_W-1:0];
          end
        end
      end
      default: begin
        // unused command: no change, all-zero answer
      end
    endcase
  end

  assign desc_re = accept && (op_n != OP_NONE);
  assign desc_q  = desc_t'(desc_rd);
  assign lvl     = tgt[LW-1:0];
  assign slot_base = AW'(lvl) * AW'(LEVEL_DEPTH);

  // read-modify-write of the descriptor fetched in the transfer cycle
  always_comb begin
    desc_we   = 1'b0;
    desc_wd   = desc_q;
    slot_we   = 1'b0;
    slot_re   = 1'b0;
    slot_addr = slot_base + AW'(desc_q.tail);
    fin       = 1'b0;
    fin_res   = res;
    ne_next   = nonempty;
    case (state)
      S_LOOK: begin
        case (op)
          OP_PUSH: begin
            fin = 1'b1;
            if (desc_q.count == CW'(LEVEL_DEPTH)) begin
              fin_res.status = ST_FULL;
            end else begin
              slot_we       = 1'b1;
              desc_we       = 1'b1;
              desc_wd.tail  = nxt_ptr(desc_q.tail);
              desc_wd.count = desc_q.count + CW'(1);
              ne_next[lvl]  = 1'b1;
            end
          end
          OP_POP: begin
            slot_re       = 1'b1;
            slot_addr     = slot_base + AW'(desc_q.head);
            desc_we       = 1'b1;
            desc_wd.head  = nxt_ptr(desc_q.head);
            desc_wd.count = desc_q.count - CW'(1);
            if (desc_q.count == CW'(1)) begin
              ne_next[lvl] = 1'b0;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_FETCH: begin
        fin                = 1'b1;
        fin_res.task_valid = 1'b1;
        fin_res.task_out   = TASK_W'(slot_rd);
      end
      S_DONE: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mfqs_desc_ram #(
    .DEPTH (NUM_LEVELS),
    .WIDTH (DW)
  ) u_desc (
    .clk   (clk),
    .rst   (rst),
    .we    (desc_we),
    .waddr (lvl),
    .wdata (desc_wd),
    .re    (desc_re),
    .raddr (tgt_n[LW-1:0]),
    .rdata (desc_rd)
  );

  mfqs_slot_ram #(
    .DEPTH (SN),
    .WIDTH (SW)
  ) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (tid),
    .re    (slot_re),
    .raddr (slot_addr),
    .rdata (slot_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      nonempty  <= '0;
    end else begin
      nonempty <= ne_next;
      // output register loads a finished result, or empties on its transfer
      if (fin && out_free) begin
        out_valid <= 1'b1;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= op_n;
            tgt   <= tgt_n;
            tid   <= SW'(req.task_id);
            res   <= res_n;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!fin) begin
            state <= S_FETCH;
          end
        end
        default: begin
        end
      endcase
      // result goes straight to the output register, or parks until it frees up
      if (fin) begin
        if (out_free) begin
          rsp_q <= fin_res;
          state <= S_IDLE;
        end else begin
          res   <= fin_res;
          state <= S_DONE;
        end
      end
    end
  end

  // a dispatch only ever targets a level whose stored count is non-zero
  a_pop_has_task: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && op == OP_POP) |-> (desc_q.count != '0))
    else $error("dispatch picked an empty level");

  // a stored count never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && op == OP_PUSH) |-> (desc_q.count <= CW'(LEVEL_DEPTH)))
    else $error("level count beyond depth");

  // a handed-out task always comes with an ok status
  a_task_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.task_valid) |-> (rsp.status == ST_OK))
    else $error("task given with error status");

  // the id fetch always follows the descriptor update of a dispatch
  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> ($past(state) == S_LOOK && op == OP_POP))
    else $error("task id fetch without dispatch");

endmodule

`default_nettype wire

// ----- dv/multilevel_feedback_queue_scheduler_tb.sv -----
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_tb;
  import mfqs_pkg::*;

  localparam int LEVELS   = 8;
  localparam int DEPTH    = 16;
  localparam int ID_BITS  = 8;
  localparam int PTR_W    = $clog2(DEPTH);
  // generous bound on the whole run, many times the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // cycles allowed for the block to settle once nothing is outstanding
  localparam int SETTLE_CYCLES = 8;
  // the one command code that the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // shadow of the scheduler: per-level ring buffers and the replies still due
  class sched_scoreboard;
    logic [TASK_W-1:0] slot_ids [LEVELS][DEPTH];
    logic [PTR_W-1:0]  rd_ptr [LEVELS];
    logic [PTR_W-1:0]  wr_ptr [LEVELS];
    logic [PTR_W:0]    fill [LEVELS];
    rsp_t              due_replies [$];
    int                errors;

    function new();
      foreach (rd_ptr[i]) begin
        rd_ptr[i] = '0;
        wr_ptr[i] = '0;
        fill[i]   = '0;
      end
      errors = 0;
    endfunction

    // append a task to one level, refusing a level out of range or full
    function status_e queue_task(input int lv, input logic [TASK_W-1:0] id);
      if (lv >= LEVELS) return ST_RANGE;
      if (fill[lv] >= DEPTH) return ST_FULL;
      slot_ids[lv][wr_ptr[lv]] = id;
      wr_ptr[lv] = PTR_W'((wr_ptr[lv] + 1) % DEPTH);
      fill[lv]++;
      return ST_OK;
    endfunction

    // work out the reply to one accepted request and update the shadow
    function void apply_request(input req_t r);
      rsp_t                 e;
      int                   nl;
      logic [TASK_W-1:0]    id;
      e  = '0;
      id = r.task_id & TASK_W'((1 << ID_BITS) - 1);
      case (r.cmd)
        CMD_ENQUEUE: begin
          e.status = queue_task(int'(r.level), id);
          if (e.status != ST_RANGE) e.level_out = LVL_OUT_W'(r.level);
        end
        CMD_DISPATCH: begin
          e.status = ST_EMPTY;
          // highest-priority level with anything waiting wins
          for (int i = 0; i < LEVELS; i++) begin
            if (fill[i] != 0) begin
              e.task_out   = slot_ids[i][rd_ptr[i]];
              rd_ptr[i]    = PTR_W'((rd_ptr[i] + 1) % DEPTH);
              fill[i]--;
              e.task_valid = 1'b1;
              e.level_out  = LVL_OUT_W'(i);
              e.status     = ST_OK;
              break;
            end
          end
        end
        CMD_FINISH: begin
          // a dead task is simply forgotten; a live one drops a level, unless already on the last one
          if (!r.is_zombie) begin
            nl = (int'(r.level) + 1 < LEVELS) ? int'(r.level) + 1 : int'(r.level);
            e.status = queue_task(nl, id);
            if (e.status != ST_RANGE) e.level_out = LVL_OUT_W'(nl);
          end
        end
        default: ;
      endcase
      due_replies.push_back(e);
    endfunction

    // compare one reply against the oldest one still due
    function void check_reply(input rsp_t got);
      rsp_t e;
      if (due_replies.size() == 0) begin
        $error("reply with none due: task_valid %0d task_out %0d level_out %0d status %0d",
               got.task_valid, got.task_out, got.level_out, got.status);
        errors++;
        return;
      end
      e = due_replies.pop_front();
      if (got.task_valid !== e.task_valid) begin
        $error("task_valid: expected %0d, got %0d", e.task_valid, got.task_valid);
        errors++;
      end
      if (got.task_out !== e.task_out) begin
        $error("task_out: expected %0d, got %0d", e.task_out, got.task_out);
        errors++;
      end
      if (got.level_out !== e.level_out) begin
        $error("level_out: expected %0d, got %0d", e.level_out, got.level_out);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  sched_scoreboard sb;
  int cycles     = 0;
  int burst_left = 0;
  // receiver stall pattern: a mode held for a random run of cycles
  int stall_mode = 0;
  int stall_run  = 0;

  multilevel_feedback_queue_scheduler #(
    .NUM_LEVELS  (LEVELS),
    .LEVEL_DEPTH (DEPTH),
    .TASK_ID_BITS(ID_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response side back-pressure: free-flowing, random, solid or light stalls
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(1, 20);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0:       rsp_stall <= 1'b0;
      1:       rsp_stall <= 1'($urandom_range(0, 1));
      2:       rsp_stall <= 1'b1;
      default: rsp_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // observe transfers on both channels; a reply is checked before the
  // request of the same edge is noted, so nothing can answer itself
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_reply(rsp);
      if (req_valid && !req_stall) sb.apply_request(req);
    end
  end

  function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                    input logic [TASK_W-1:0] id,
                                    input logic [LEVEL_W-1:0] lv,
                                    input logic zombie);
    req_t r;
    r.cmd       = cmd;
    r.task_id   = id;
    r.level     = lv;
    r.is_zombie = zombie;
    return r;
  endfunction

  // random request; hot_level soaks up half of the in-range levels so
  // that some level fills up, dispatch_pct sets the drain rate
  function automatic req_t random_req(input int dispatch_pct, input int hot_level);
    req_t r;
    int   pick;
    r.task_id   = TASK_W'($urandom_range(0, 255));
    r.is_zombie = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) == 0)      r.level = LEVEL_W'($urandom_range(LEVELS, 15));
    else if ($urandom_range(0, 1) == 0) r.level = LEVEL_W'(hot_level);
    else                                r.level = LEVEL_W'($urandom_range(0, LEVELS - 1));
    pick = $urandom_range(0, 99);
    if (pick == 99)                r.cmd = CMD_NOP;
    else if (pick < dispatch_pct)  r.cmd = CMD_DISPATCH;
    else if (pick % 2 == 0)        r.cmd = CMD_ENQUEUE;
    else                           r.cmd = CMD_FINISH;
    return r;
  endfunction

  // present one request and hold it until the transfer, then maybe idle
  task automatic send_req(input req_t r);
    int gap;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      // a zero gap keeps valid high into the next request
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // hold off the request side until every reply has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.due_replies.size() != 0);
    burst_left = $urandom_range(1, 10);
  endtask

  initial begin
    int hot;
    int dispatch_pct;
    sb = new();
    burst_left = $urandom_range(1, 10);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing ready yet
    send_req(make_req(CMD_DISPATCH, 8'd0, 4'd0, 1'b0));
    // fill one level with extreme ids first; the seventeenth is refused as full
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_req(make_req(CMD_ENQUEUE,
                        (i == 0) ? 8'd255 : (i == 1) ? 8'd0 : TASK_W'($urandom_range(0, 255)),
                        4'd5, 1'b1));
    end
    // levels out of range on enqueue and on a live finish
    send_req(make_req(CMD_ENQUEUE, 8'hAA, 4'd8, 1'b0));
    send_req(make_req(CMD_ENQUEUE, 8'h55, 4'd15, 1'b0));
    send_req(make_req(CMD_FINISH, 8'h0F, 4'd15, 1'b0));
    // a zombie finish is fine whatever the level
    send_req(make_req(CMD_FINISH, 8'hF0, 4'd15, 1'b1));
    // live finish at the lowest level stays there, at the top it drops one
    send_req(make_req(CMD_FINISH, 8'd255, 4'd7, 1'b0));
    send_req(make_req(CMD_FINISH, 8'h3C, 4'd0, 1'b0));
    // unused command with every field bit set
    send_req(make_req(CMD_NOP, 8'd255, 4'd15, 1'b1));
    for (int i = 0; i < 3; i++) send_req(make_req(CMD_DISPATCH, 8'd0, 4'd0, 1'b0));
    wait_drained();

    // alternate filling and draining phases, sometimes waiting for every reply in between
    for (int ph = 0; ph < 8; ph++) begin
      hot          = $urandom_range(0, LEVELS - 1);
      dispatch_pct = (ph % 2 == 0) ? 10 : 70;
      for (int n = 0; n < 125; n++) send_req(random_req(dispatch_pct, hot));
      if (ph % 3 == 2) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mfqs_pkg.sv
src/mfqs_slot_ram.sv
src/mfqs_desc_ram.sv
src/multilevel_feedback_queue_scheduler.sv
dv/multilevel_feedback_queue_scheduler_tb.sv
